// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/kcg_pkg.sv
package kcg_pkg;

  localparam int SET_W     = 7;
  localparam int CHOOSE_W  = 5;
  localparam int OFFSET_W  = 16;
  localparam int VALUE_W   = 17;
  localparam int POS_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOOSE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SEARCH,
    ST_EMIT,
    ST_EMPTY,
    ST_ADV_FIRST,
    ST_ADV_FILL
  } state_t;

  typedef struct packed {
    logic start;
    logic init_write;
    logic search_step;
    logic read_pos;
    logic emit;
    logic emit_empty;
    logic adv_first;
    logic adv_fill;
  } cmd_t;

  typedef struct packed {
    logic usable;
    logic cfg_hit;
    logic pos_last;
    logic run_last;
    logic run_zero;
    logic found;
    logic final_comb;
    logic out_free;
  } status_t;

endpackage

// File: hdl/k_combination_generator.sv
// Lexicographic k-combination generator: each accepted request emits the current
// combination of base_offset .. base_offset+n-1 as k transfers (positions 0..k-1),
// then steps to the next combination, or a single empty transfer when none remains
// or the configuration admits none. The indices live in a single-ported register
// file walked one entry per cycle while the output is not stalled: a request has an
// accept step, a fill of all k indices after reset, a restart or a config write,
// a search from the right for the rightmost index below its limit, k output
// transfers and, unless it is the final combination, a refill from that index
// rightwards; an empty request has only accept and empty steps. No clearing pass.
module k_combination_generator
  import kcg_pkg::*;
#(
  parameter int MAX_CHOOSE = 16,
  parameter int MAX_SET    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VALUE_W-1:0]   element_value,
  output logic [POS_W-1:0]     element_position,
  output logic                 last_element,
  output logic                 last_combination,
  output logic                 empty_res
);

  cmd_t    cmd;
  status_t status;

  kcg_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .restart  (restart),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  kcg_datapath #(
    .MAX_CHOOSE (MAX_CHOOSE),
    .MAX_SET    (MAX_SET)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .element_value    (element_value),
    .element_position (element_position),
    .last_element     (last_element),
    .last_combination (last_combination),
    .empty_res        (empty_res)
  );

endmodule

// File: hdl/kcg_controller.sv
module kcg_controller
  import kcg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    restart,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   need_start;
  logic   exhausted;
  logic   accept;

  assign accept = (state == ST_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      need_start <= 1'b1;
      exhausted  <= 1'b0;
    end else if (status.cfg_hit) begin
      need_start <= 1'b1;
      exhausted  <= 1'b0;
    end else if (accept && status.usable && (restart || need_start)) begin
      need_start <= 1'b0;
      exhausted  <= 1'b0;
    end else if (state == ST_EMIT && status.out_free && status.pos_last &&
                 status.final_comb) begin
      exhausted <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!status.usable) begin
            state_next = ST_EMPTY;
          end else if (restart || need_start) begin
            state_next = ST_INIT;
          end else if (exhausted) begin
            state_next = ST_EMPTY;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_INIT: begin
        if (status.pos_last) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.found || status.run_zero) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.pos_last) begin
          state_next = status.final_comb ? ST_IDLE : ST_ADV_FIRST;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_ADV_FIRST: begin
        state_next = status.run_last ? ST_IDLE : ST_ADV_FILL;
      end
      ST_ADV_FILL: begin
        if (status.run_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_INIT: begin
        cmd.init_write = 1'b1;
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.read_pos = 1'b1;
        cmd.emit     = status.out_free;
      end
      ST_EMPTY: begin
        cmd.emit_empty = status.out_free;
      end
      ST_ADV_FIRST: begin
        cmd.adv_first = 1'b1;
      end
      ST_ADV_FILL: begin
        cmd.adv_fill = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hdl/kcg_datapath.sv
module kcg_datapath
  import kcg_pkg::*;
#(
  parameter int MAX_CHOOSE = 16,
  parameter int MAX_SET    = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VALUE_W-1:0]   element_value,
  output logic [POS_W-1:0]     element_position,
  output logic                 last_element,
  output logic                 last_combination,
  output logic                 empty_res
);

  localparam int AW = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
  localparam int KW = (AW > CHOOSE_W) ? AW : CHOOSE_W;
  localparam int IW = $clog2(MAX_SET);
  localparam int NW = ($clog2(MAX_SET + 1) > SET_W) ? $clog2(MAX_SET + 1) : SET_W;

  logic [SET_W-1:0]    set_size;
  logic [CHOOSE_W-1:0] choose_count;
  logic [OFFSET_W-1:0] base_offset;

  logic [IW-1:0] store [MAX_CHOOSE];
  logic [KW-1:0] pos;
  logic [KW-1:0] run;
  logic [IW-1:0] fill;
  logic          final_comb;

  logic [NW-1:0] n_eff;
  logic [NW-1:0] limit;
  logic [KW-1:0] k_m1;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [IW-1:0] rd_data;
  logic [IW-1:0] wr_data;
  logic          wr_en;
  logic          cfg_hit;
  logic          out_free;

  assign cfg_hit = cfg_write && (cfg_index == REG_SET_SIZE || cfg_index == REG_CHOOSE ||
                                 cfg_index == REG_BASE_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size     <= SET_W'(1);
      choose_count <= CHOOSE_W'(1);
      base_offset  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SET_SIZE:    set_size     <= cfg_data[SET_W-1:0];
        REG_CHOOSE:      choose_count <= cfg_data[CHOOSE_W-1:0];
        REG_BASE_OFFSET: base_offset  <= cfg_data[OFFSET_W-1:0];
        default:         ;
      endcase
    end
  end

  assign n_eff = (NW'(set_size) > NW'(MAX_SET)) ? NW'(MAX_SET) : NW'(set_size);
  assign k_m1  = KW'(choose_count) - KW'(1);
  assign limit = n_eff - NW'(choose_count) + NW'(run);

  assign rd_addr = cmd.read_pos ? pos[AW-1:0] : run[AW-1:0];
  assign rd_data = store[rd_addr];

  assign wr_en   = cmd.init_write || cmd.adv_first || cmd.adv_fill;
  assign wr_addr = cmd.init_write ? pos[AW-1:0] : run[AW-1:0];
  always_comb begin
    if (cmd.init_write) begin
      wr_data = IW'(pos);
    end else if (cmd.adv_first) begin
      wr_data = rd_data + IW'(1);
    end else begin
      wr_data = fill + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (cmd.adv_first || cmd.adv_fill) begin
      fill <= wr_data;
    end
    if (cmd.search_step) begin
      final_comb <= !status.found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      run <= '0;
    end else begin
      if (cmd.start) begin
        pos <= '0;
      end else if (cmd.init_write) begin
        pos <= status.pos_last ? '0 : pos + KW'(1);
      end else if (cmd.emit) begin
        pos <= pos + KW'(1);
      end
      if (cmd.start) begin
        run <= k_m1;
      end else if (cmd.search_step && !status.found && !status.run_zero) begin
        run <= run - KW'(1);
      end else if ((cmd.adv_first || cmd.adv_fill) && !status.run_last) begin
        run <= run + KW'(1);
      end
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      element_value    <= VALUE_W'(rd_data) + VALUE_W'(base_offset);
      element_position <= POS_W'(pos);
      last_element     <= status.pos_last;
      last_combination <= final_comb;
      empty_res        <= 1'b0;
    end else if (cmd.emit_empty) begin
      element_value    <= '0;
      element_position <= '0;
      last_element     <= 1'b1;
      last_combination <= 1'b0;
      empty_res        <= 1'b1;
    end
  end

  always_comb begin
    status.usable     = (choose_count != '0) &&
                        (NW'(choose_count) <= NW'(MAX_CHOOSE)) &&
                        (NW'(choose_count) <= n_eff);
    status.cfg_hit    = cfg_hit;
    status.pos_last   = (pos == k_m1);
    status.run_last   = (run == k_m1);
    status.run_zero   = (run == '0);
    status.found      = (NW'(rd_data) < limit);
    status.final_comb = final_comb;
    status.out_free   = out_free;
  end

endmodule

// File: hdl/kcg_checker.sv
`include "assert_macros.svh"

module kcg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] element_value,
  input logic [3:0]  element_position,
  input logic        last_element,
  input logic        last_combination,
  input logic        empty_res
);

  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(element_value) && $stable(element_position) && $stable(last_element) && $stable(last_combination) && $stable(empty_res), "stalled output transfer changed")

  `CHK_NOW(a_empty_form, out_valid && empty_res, last_element && !last_combination && element_position == 4'd0 && element_value == 17'd0, "malformed empty transfer")

  `CHK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request taken while previous one in flight")

  `CHK_NEXT(a_position_step, out_valid && !out_stall && !last_element, out_valid && !empty_res && element_position == 4'($past(element_position) + 4'd1) && last_combination == $past(last_combination), "element sequence broken")

endmodule

bind k_combination_generator kcg_checker u_kcg_checker (.*);
